### design/ptcm_pkg.sv
// Shared types and constants for the pan/tilt move controller.
// No dependencies; every other file of the block uses it.
package ptcm_pkg;

  localparam int PAN_W   = 18;
  localparam int TILT_W  = 16;
  localparam int DPAN_W  = 17;
  localparam int DTILT_W = 16;
  localparam int GEAR_W  = 8;
  localparam int SPD_W   = 9;
  localparam int GAIN_W  = 10;
  localparam int LIMIT_W = 15;

  // serial multiplier: 17-bit multiplicand, 8-bit multiplier, one bit per cycle
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 8;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W;

  // serial divider: one quotient bit per cycle
  localparam int DIV_N_W   = 26;
  localparam int DIV_D_W   = 18;
  localparam int DIV_Q_W   = 8;
  localparam int DIV_STEPS = DIV_Q_W;

  localparam logic signed [PAN_W-1:0] FULL_TURN = 18'sd36000;
  localparam logic signed [19:0] PAN_MAX  = 20'sd131071;
  localparam logic signed [19:0] PAN_MIN  = -20'sd131072;
  localparam logic signed [19:0] TILT_MAX = 20'sd32767;
  localparam logic signed [19:0] TILT_MIN = -20'sd32768;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 10'd60;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd5800;

  localparam logic REG_STEP_GAIN  = 1'b0;
  localparam logic REG_TILT_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_STOP   = 2'd2
  } op_t;

endpackage

### design/ptcm_if.sv
// Valid/ready channel interfaces: command items in, status items out.
// Depends on ptcm_pkg for field widths.
interface ptcm_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           opcode;
  logic signed [ptcm_pkg::DPAN_W-1:0]   delta_pan;
  logic signed [ptcm_pkg::DTILT_W-1:0]  delta_tilt;
  logic [ptcm_pkg::GEAR_W-1:0]          max_speed_pan;
  logic [ptcm_pkg::GEAR_W-1:0]          max_speed_tilt;

  modport source (output valid, opcode, delta_pan, delta_tilt, max_speed_pan,
                  max_speed_tilt, input ready);
  modport sink (input valid, opcode, delta_pan, delta_tilt, max_speed_pan,
                max_speed_tilt, output ready);
endinterface

interface ptcm_stat_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptcm_pkg::PAN_W-1:0]   pan_position;
  logic signed [ptcm_pkg::TILT_W-1:0]  tilt_position;
  logic signed [ptcm_pkg::SPD_W-1:0]   pan_velocity;
  logic signed [ptcm_pkg::SPD_W-1:0]   tilt_velocity;
  logic                                move_done;

  modport source (output valid, pan_position, tilt_position, pan_velocity,
                  tilt_velocity, move_done, input ready);
  modport sink (input valid, pan_position, tilt_position, pan_velocity,
                tilt_velocity, move_done, output ready);
endinterface

### design/ptcm_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ptcm_pkg for widths and step count.
module ptcm_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ptcm_pkg::MUL_A_W-1:0]    mcand,
  input  logic [ptcm_pkg::MUL_B_W-1:0]    mplier,
  output logic                            done,
  output logic [ptcm_pkg::MUL_P_W-1:0]    product
);

  localparam int CNT_W = $clog2(ptcm_pkg::MUL_STEPS + 1);

  logic                          run;
  logic [CNT_W-1:0]              cnt;
  logic [ptcm_pkg::MUL_P_W-1:0]  mc_sh;
  logic [ptcm_pkg::MUL_B_W-1:0]  mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(ptcm_pkg::MUL_STEPS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      mc_sh   <= ptcm_pkg::MUL_P_W'(mcand);
      mp      <= mplier;
    end else if (run) begin
      if (mp[0]) begin
        product <= product + mc_sh;
      end
      mc_sh <= mc_sh << 1;
      mp    <= mp >> 1;
    end
  end

endmodule

### design/ptcm_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit.
// Depends on ptcm_pkg for widths and step count.
module ptcm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ptcm_pkg::DIV_N_W-1:0]  num,
  input  logic [ptcm_pkg::DIV_D_W-1:0]  den,
  output logic                          done,
  output logic [ptcm_pkg::DIV_Q_W-1:0]  quot
);

  localparam int CNT_W = $clog2(ptcm_pkg::DIV_STEPS + 1);

  logic                          run;
  logic [CNT_W-1:0]              cnt;
  logic [ptcm_pkg::DIV_N_W-1:0]  rem;
  logic [ptcm_pkg::DIV_N_W-1:0]  dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(ptcm_pkg::DIV_STEPS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= ptcm_pkg::DIV_N_W'(den) << (ptcm_pkg::DIV_Q_W - 1);
      quot <= '0;
    end else if (run) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[ptcm_pkg::DIV_Q_W-2:0], 1'b1};
      end else begin
        quot <= {quot[ptcm_pkg::DIV_Q_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

### design/pan_tilt_coordinated_move.sv
// Pan/tilt move controller top level: sequencer, state, config registers.
// Depends on ptcm_pkg, ptcm_if, ptcm_mul, ptcm_div.
//
// Usage: command items enter on cmd (valid/ready), one status item per
// command leaves on stat (valid/ready). Commands: tick, rotate relative,
// stop. Registers step_gain (addr 0) and tilt_limit (addr 4) sit on the
// APB port; write them only while no command is in flight.
// Sequence from accept to status valid:
//   rotate: RSET, then a serial multiply of a*T and b*P (RMUL), then a
//           serial rounded division for the slower axis gear (RDIV)
//   tick:   a serial speed*gain multiply (TMUL) while moving, the pan
//           wrap (WRAP, one 36000 add or subtract per cycle) when the
//           move ends, straight to the status register when already done
//   stop and the unused opcode: straight to the status register
// One command is in work at a time; cmd.ready is high while idle. The
// status register lets the next command enter while a status item waits.
// If stat stalls, the block holds the finished status and waits before
// loading another one; nothing is dropped.
// Reset: positions, targets and speeds zero, move done, step_gain 60,
// tilt_limit 5800.
module pan_tilt_coordinated_move #(
  parameter int SPEED_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  ptcm_cmd_if.sink           cmd,
  ptcm_stat_if.source        stat,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [ptcm_pkg::GEAR_W-1:0] GEAR_TOP =
    (SPEED_BITS >= ptcm_pkg::GEAR_W) ? {ptcm_pkg::GEAR_W{1'b1}}
                                     : ptcm_pkg::GEAR_W'((1 << SPEED_BITS) - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RSET   = 7'b0000010,
    S_RMUL   = 7'b0000100,
    S_RDIV   = 7'b0001000,
    S_TMUL   = 7'b0010000,
    S_WRAP   = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t state;

  // config
  logic [ptcm_pkg::GAIN_W-1:0]  step_gain;
  logic [ptcm_pkg::LIMIT_W-1:0] tilt_limit;

  // architectural state
  logic signed [ptcm_pkg::PAN_W-1:0]  pan_pos, pan_target;
  logic signed [ptcm_pkg::TILT_W-1:0] tilt_pos, tilt_target;
  logic signed [ptcm_pkg::SPD_W-1:0]  pan_speed, tilt_speed;
  logic                               done_flag;

  // per-item working registers
  logic                                pm, tm, pan_long;
  logic signed [ptcm_pkg::DPAN_W-1:0]  dp;
  logic signed [ptcm_pkg::DTILT_W-1:0] dt;
  logic [ptcm_pkg::GEAR_W-1:0]         lp, lt, lpx, ltx;
  logic [ptcm_pkg::MUL_A_W-1:0]        a_mag, b_mag;

  // status register
  logic                               out_valid;
  logic signed [ptcm_pkg::PAN_W-1:0]  out_pan;
  logic signed [ptcm_pkg::TILT_W-1:0] out_tilt;
  logic signed [ptcm_pkg::SPD_W-1:0]  out_pan_vel, out_tilt_vel;
  logic                               out_done;

  logic accept, load_out;

  // speed magnitudes and motion test
  logic signed [ptcm_pkg::SPD_W-1:0] pan_speed_neg, tilt_speed_neg;
  logic [ptcm_pkg::GEAR_W-1:0]       pan_mag, tilt_mag;
  logic                              pm_c, tm_c;

  // rotate setup
  logic signed [ptcm_pkg::DPAN_W-1:0]  dp_neg, dt_x, dt_neg;
  logic [ptcm_pkg::MUL_A_W-1:0]        a_c, b_c;
  logic [ptcm_pkg::GEAR_W-1:0]         lpx_c, ltx_c;
  logic signed [ptcm_pkg::PAN_W:0]     pan_sum;
  logic signed [ptcm_pkg::DPAN_W-1:0]  tilt_sum, lim_pos, lim_neg;
  logic signed [ptcm_pkg::PAN_W-1:0]   pan_tgt_c;
  logic signed [ptcm_pkg::TILT_W-1:0]  tilt_tgt_c;

  // multipliers
  logic                          mul_start;
  logic [ptcm_pkg::MUL_A_W-1:0]  m0_a, m1_a;
  logic [ptcm_pkg::MUL_B_W-1:0]  m0_b, m1_b;
  logic                          mul0_done, mul1_done;
  logic [ptcm_pkg::MUL_P_W-1:0]  prod0, prod1;

  // divider
  logic                          div_start, div_done, zero_move, pan_long_c;
  logic [ptcm_pkg::DIV_N_W-1:0]  div_num;
  logic [ptcm_pkg::DIV_D_W-1:0]  div_den;
  logic [ptcm_pkg::DIV_Q_W-1:0]  quot;
  logic [ptcm_pkg::GEAR_W-1:0]   pmag_sel, tmag_sel, pmag_sat, tmag_sat;
  logic signed [ptcm_pkg::SPD_W-1:0] pan_speed_c, tilt_speed_c;

  // tick step
  logic signed [19:0]                  pan_step20, tilt_step20;
  logic signed [ptcm_pkg::PAN_W-1:0]   pan_step_c;
  logic signed [ptcm_pkg::TILT_W-1:0]  tilt_step_c;

  // wrap
  logic signed [ptcm_pkg::PAN_W-1:0] pan_pos_w, pan_tgt_w;
  logic                              wrap_ok;

  // ---------------- APB ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain  <= ptcm_pkg::GAIN_RESET;
      tilt_limit <= ptcm_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ptcm_pkg::REG_STEP_GAIN:  step_gain  <= pwdata[ptcm_pkg::GAIN_W-1:0];
        ptcm_pkg::REG_TILT_LIMIT: tilt_limit <= pwdata[ptcm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ptcm_pkg::REG_STEP_GAIN:  prdata = 32'(step_gain);
      ptcm_pkg::REG_TILT_LIMIT: prdata = 32'(tilt_limit);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- handshakes ----------------
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign load_out  = (state == S_RESULT) && (!out_valid || stat.ready);

  assign stat.valid         = out_valid;
  assign stat.pan_position  = out_pan;
  assign stat.tilt_position = out_tilt;
  assign stat.pan_velocity  = out_pan_vel;
  assign stat.tilt_velocity = out_tilt_vel;
  assign stat.move_done     = out_done;

  // ---------------- combinational datapath ----------------
  always_comb begin
    pan_speed_neg  = -pan_speed;
    tilt_speed_neg = -tilt_speed;
    pan_mag  = pan_speed[ptcm_pkg::SPD_W-1] ? pan_speed_neg[ptcm_pkg::GEAR_W-1:0]
                                            : pan_speed[ptcm_pkg::GEAR_W-1:0];
    tilt_mag = tilt_speed[ptcm_pkg::SPD_W-1] ? tilt_speed_neg[ptcm_pkg::GEAR_W-1:0]
                                             : tilt_speed[ptcm_pkg::GEAR_W-1:0];
    pm_c = (pan_speed > 0 && pan_pos < pan_target) ||
           (pan_speed < 0 && pan_pos > pan_target);
    tm_c = (tilt_speed > 0 && tilt_pos < tilt_target) ||
           (tilt_speed < 0 && tilt_pos > tilt_target);
  end

  always_comb begin
    dp_neg = -dp;
    dt_x   = ptcm_pkg::DPAN_W'(dt);
    dt_neg = -dt_x;
    a_c    = dp[ptcm_pkg::DPAN_W-1] ? $unsigned(dp_neg) : $unsigned(dp);
    b_c    = dt[ptcm_pkg::DTILT_W-1] ? $unsigned(dt_neg) : $unsigned(dt_x);
    lpx_c  = (lp == '0) ? ptcm_pkg::GEAR_W'(1) : lp;
    ltx_c  = (lt == '0) ? ptcm_pkg::GEAR_W'(1) : lt;

    pan_sum = (ptcm_pkg::PAN_W+1)'(pan_pos) + (ptcm_pkg::PAN_W+1)'(dp);
    if (pan_sum > (ptcm_pkg::PAN_W+1)'(ptcm_pkg::PAN_MAX)) begin
      pan_tgt_c = ptcm_pkg::PAN_W'(ptcm_pkg::PAN_MAX);
    end else if (pan_sum < (ptcm_pkg::PAN_W+1)'(ptcm_pkg::PAN_MIN)) begin
      pan_tgt_c = ptcm_pkg::PAN_W'(ptcm_pkg::PAN_MIN);
    end else begin
      pan_tgt_c = pan_sum[ptcm_pkg::PAN_W-1:0];
    end

    tilt_sum = ptcm_pkg::DPAN_W'(tilt_pos) + ptcm_pkg::DPAN_W'(dt);
    lim_pos  = $signed({2'b00, tilt_limit});
    lim_neg  = -lim_pos;
    if (tilt_sum < lim_neg) begin
      tilt_tgt_c = lim_neg[ptcm_pkg::TILT_W-1:0];
    end else if (tilt_sum > lim_pos) begin
      tilt_tgt_c = lim_pos[ptcm_pkg::TILT_W-1:0];
    end else begin
      tilt_tgt_c = tilt_sum[ptcm_pkg::TILT_W-1:0];
    end
  end

  // rotate: a*T and b*P; tick: gain times speed magnitude
  always_comb begin
    if (state == S_RSET) begin
      m0_a = a_c;
      m0_b = ltx_c;
      m1_a = b_c;
      m1_b = lpx_c;
    end else begin
      m0_a = ptcm_pkg::MUL_A_W'(step_gain);
      m0_b = pan_mag;
      m1_a = ptcm_pkg::MUL_A_W'(step_gain);
      m1_b = tilt_mag;
    end
  end

  assign mul_start = (state == S_RSET) ||
                     (accept && cmd.opcode == ptcm_pkg::OP_TICK && !done_flag &&
                      (pm_c || tm_c));

  ptcm_mul u_mul0 (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (m0_a),
    .mplier  (m0_b),
    .done    (mul0_done),
    .product (prod0)
  );

  ptcm_mul u_mul1 (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (m1_a),
    .mplier  (m1_b),
    .done    (mul1_done),
    .product (prod1)
  );

  // rounded division: (2*small + big_axis_delta) / (2*big_axis_delta)
  always_comb begin
    zero_move  = (a_mag == '0) && (b_mag == '0);
    pan_long_c = prod0 > prod1;
    if (pan_long_c) begin
      div_num = {prod1, 1'b0} + ptcm_pkg::DIV_N_W'(a_mag);
      div_den = {a_mag, 1'b0};
    end else begin
      div_num = {prod0, 1'b0} + ptcm_pkg::DIV_N_W'(b_mag);
      div_den = {b_mag, 1'b0};
    end
  end

  assign div_start = (state == S_RMUL) && mul0_done && !zero_move;

  ptcm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    pmag_sel = pan_long ? lpx : quot;
    tmag_sel = pan_long ? quot : ltx;
    pmag_sat = (pmag_sel > GEAR_TOP) ? GEAR_TOP : pmag_sel;
    tmag_sat = (tmag_sel > GEAR_TOP) ? GEAR_TOP : tmag_sel;
    if (dp == '0) begin
      pan_speed_c = '0;
    end else if (dp[ptcm_pkg::DPAN_W-1]) begin
      pan_speed_c = -$signed({1'b0, pmag_sat});
    end else begin
      pan_speed_c = $signed({1'b0, pmag_sat});
    end
    if (dt == '0) begin
      tilt_speed_c = '0;
    end else if (dt[ptcm_pkg::DTILT_W-1]) begin
      tilt_speed_c = -$signed({1'b0, tmag_sat});
    end else begin
      tilt_speed_c = $signed({1'b0, tmag_sat});
    end
  end

  // tick step with saturation
  always_comb begin
    if (pan_speed[ptcm_pkg::SPD_W-1]) begin
      pan_step20 = 20'(pan_pos) - $signed({2'b00, prod0[17:0]});
    end else begin
      pan_step20 = 20'(pan_pos) + $signed({2'b00, prod0[17:0]});
    end
    if (tilt_speed[ptcm_pkg::SPD_W-1]) begin
      tilt_step20 = 20'(tilt_pos) - $signed({2'b00, prod1[17:0]});
    end else begin
      tilt_step20 = 20'(tilt_pos) + $signed({2'b00, prod1[17:0]});
    end
    if (pan_step20 > ptcm_pkg::PAN_MAX) begin
      pan_step_c = ptcm_pkg::PAN_W'(ptcm_pkg::PAN_MAX);
    end else if (pan_step20 < ptcm_pkg::PAN_MIN) begin
      pan_step_c = ptcm_pkg::PAN_W'(ptcm_pkg::PAN_MIN);
    end else begin
      pan_step_c = pan_step20[ptcm_pkg::PAN_W-1:0];
    end
    if (tilt_step20 > ptcm_pkg::TILT_MAX) begin
      tilt_step_c = ptcm_pkg::TILT_W'(ptcm_pkg::TILT_MAX);
    end else if (tilt_step20 < ptcm_pkg::TILT_MIN) begin
      tilt_step_c = ptcm_pkg::TILT_W'(ptcm_pkg::TILT_MIN);
    end else begin
      tilt_step_c = tilt_step20[ptcm_pkg::TILT_W-1:0];
    end
  end

  // pan wrap, one turn per cycle
  always_comb begin
    if (pan_pos < 0) begin
      pan_pos_w = pan_pos + ptcm_pkg::FULL_TURN;
    end else if (pan_pos >= ptcm_pkg::FULL_TURN) begin
      pan_pos_w = pan_pos - ptcm_pkg::FULL_TURN;
    end else begin
      pan_pos_w = pan_pos;
    end
    if (pan_target < 0) begin
      pan_tgt_w = pan_target + ptcm_pkg::FULL_TURN;
    end else if (pan_target >= ptcm_pkg::FULL_TURN) begin
      pan_tgt_w = pan_target - ptcm_pkg::FULL_TURN;
    end else begin
      pan_tgt_w = pan_target;
    end
    wrap_ok = (pan_pos_w == pan_pos) && (pan_tgt_w == pan_target);
  end

  // ---------------- sequencer and state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pan_pos     <= '0;
      tilt_pos    <= '0;
      pan_target  <= '0;
      tilt_target <= '0;
      pan_speed   <= '0;
      tilt_speed  <= '0;
      done_flag   <= 1'b1;
      pm          <= 1'b0;
      tm          <= 1'b0;
      pan_long    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.opcode)
              ptcm_pkg::OP_TICK: begin
                if (done_flag) begin
                  state <= S_RESULT;
                end else if (pm_c || tm_c) begin
                  pm    <= pm_c;
                  tm    <= tm_c;
                  state <= S_TMUL;
                end else begin
                  state <= S_WRAP;
                end
              end
              ptcm_pkg::OP_ROTATE: state <= S_RSET;
              ptcm_pkg::OP_STOP: begin
                pan_target  <= pan_pos;
                tilt_target <= tilt_pos;
                pan_speed   <= '0;
                tilt_speed  <= '0;
                done_flag   <= 1'b1;
                state       <= S_RESULT;
              end
              default: state <= S_RESULT;
            endcase
          end
        end
        S_RSET: begin
          pan_target  <= pan_tgt_c;
          tilt_target <= tilt_tgt_c;
          done_flag   <= 1'b0;
          state       <= S_RMUL;
        end
        S_RMUL: begin
          if (mul0_done) begin
            if (zero_move) begin
              pan_speed  <= '0;
              tilt_speed <= '0;
              state      <= S_RESULT;
            end else begin
              pan_long <= pan_long_c;
              state    <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          if (div_done) begin
            pan_speed  <= pan_speed_c;
            tilt_speed <= tilt_speed_c;
            state      <= S_RESULT;
          end
        end
        S_TMUL: begin
          if (mul1_done) begin
            if (pm) pan_pos <= pan_step_c;
            if (tm) tilt_pos <= tilt_step_c;
            state <= S_RESULT;
          end
        end
        S_WRAP: begin
          if (wrap_ok) begin
            done_flag <= 1'b1;
            state     <= S_RESULT;
          end else begin
            pan_pos    <= pan_pos_w;
            pan_target <= pan_tgt_w;
          end
        end
        S_RESULT: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item payload and rotate operands
  always_ff @(posedge clk) begin
    if (accept) begin
      dp <= cmd.delta_pan;
      dt <= cmd.delta_tilt;
      lp <= cmd.max_speed_pan;
      lt <= cmd.max_speed_tilt;
    end
    if (state == S_RSET) begin
      a_mag <= a_c;
      b_mag <= b_c;
      lpx   <= lpx_c;
      ltx   <= ltx_c;
    end
  end

  // status register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (stat.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pan      <= pan_pos;
      out_tilt     <= tilt_pos;
      out_pan_vel  <= pan_speed;
      out_tilt_vel <= tilt_speed;
      out_done     <= done_flag;
    end
  end

endmodule

### tb/pan_tilt_coordinated_move_tb.sv
// Self-checking testbench for the pan/tilt move controller.
// Drives commands and APB register writes, predicts each status item and checks it.
// Depends on ptcm_pkg, ptcm_if and the pan_tilt_coordinated_move RTL.
`timescale 1ns / 1ps

module pan_tilt_coordinated_move_tb;
  import ptcm_pkg::*;

  localparam int SPEED_BITS     = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 25;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                opcode;
    logic signed [DPAN_W-1:0]  delta_pan;
    logic signed [DTILT_W-1:0] delta_tilt;
    logic [GEAR_W-1:0]         gear_pan;
    logic [GEAR_W-1:0]         gear_tilt;
  } move_cmd_t;

  typedef struct {
    logic signed [PAN_W-1:0]  pan_pos;
    logic signed [TILT_W-1:0] tilt_pos;
    logic signed [SPD_W-1:0]  pan_vel;
    logic signed [SPD_W-1:0]  tilt_vel;
    logic                     done;
  } axis_status_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ptcm_cmd_if  cmd_bus ();
  ptcm_stat_if stat_bus ();

  pan_tilt_coordinated_move #(
    .SPEED_BITS(SPEED_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_bus),
    .stat    (stat_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the controller state
  logic signed [PAN_W-1:0]  m_pan_pos;
  logic signed [PAN_W-1:0]  m_pan_tgt;
  logic signed [TILT_W-1:0] m_tilt_pos;
  logic signed [TILT_W-1:0] m_tilt_tgt;
  logic signed [SPD_W-1:0]  m_pan_spd;
  logic signed [SPD_W-1:0]  m_tilt_spd;
  logic                     m_done;
  logic [GAIN_W-1:0]        m_gain;
  logic [LIMIT_W-1:0]       m_tilt_lim;

  axis_status_t pending_status[$];

  int  src_idle_pct;
  int  snk_idle_pct;
  bit  hold_off_req;
  int  quiet_cycles;
  int  mismatches;
  int  results_checked;
  int  work_items;
  int  n_rotate;
  int  n_tick;
  int  n_stop;
  int  n_other;
  int  n_settings;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint wrap_turn(longint v);
    v = v % longint'(FULL_TURN);
    if (v < 0) v += longint'(FULL_TURN);
    return v;
  endfunction

  function automatic longint sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint gear_cap(longint v);
    longint top = (longint'(1) << SPEED_BITS) - 1;
    return (v > top) ? top : v;
  endfunction

  function automatic void start_move(move_cmd_t c);
    longint dp, dt, a, b, lp, lt, sp, st, lim;
    dp  = c.delta_pan;
    dt  = c.delta_tilt;
    a   = (dp < 0) ? -dp : dp;
    b   = (dt < 0) ? -dt : dt;
    lp  = (c.gear_pan == 0) ? 1 : longint'(c.gear_pan);
    lt  = (c.gear_tilt == 0) ? 1 : longint'(c.gear_tilt);
    lim = m_tilt_lim;
    m_pan_tgt  = clip(longint'(m_pan_pos) + dp, PAN_MIN, PAN_MAX);
    m_tilt_tgt = clip(longint'(m_tilt_pos) + dt, -lim, lim);
    if (a == 0 && b == 0) begin
      sp = 0;
      st = 0;
    end else if (a * lt > b * lp) begin
      sp = lp;
      st = (2 * b * lp + a) / (2 * a);
    end else begin
      st = lt;
      sp = (2 * a * lt + b) / (2 * b);
    end
    m_pan_spd  = sign_of(dp) * gear_cap(sp);
    m_tilt_spd = sign_of(dt) * gear_cap(st);
    m_done     = 1'b0;
  endfunction

  function automatic void step_axes();
    longint g;
    bit     pan_moving, tilt_moving;
    g = m_gain;
    pan_moving  = (m_pan_spd > 0 && m_pan_pos < m_pan_tgt) ||
                  (m_pan_spd < 0 && m_pan_pos > m_pan_tgt);
    tilt_moving = (m_tilt_spd > 0 && m_tilt_pos < m_tilt_tgt) ||
                  (m_tilt_spd < 0 && m_tilt_pos > m_tilt_tgt);
    if (pan_moving)
      m_pan_pos = clip(longint'(m_pan_pos) + longint'(m_pan_spd) * g, PAN_MIN, PAN_MAX);
    if (tilt_moving)
      m_tilt_pos = clip(longint'(m_tilt_pos) + longint'(m_tilt_spd) * g, TILT_MIN, TILT_MAX);
    if (!pan_moving && !tilt_moving) begin
      m_pan_pos = wrap_turn(m_pan_pos);
      m_pan_tgt = wrap_turn(m_pan_tgt);
      m_done    = 1'b1;
    end
  endfunction

  function automatic axis_status_t advance_axes(move_cmd_t c);
    axis_status_t s;
    case (c.opcode)
      OP_TICK: begin
        n_tick++;
        if (!m_done) begin
          work_items++;
          step_axes();
        end
      end
      OP_ROTATE: begin
        n_rotate++;
        work_items++;
        start_move(c);
      end
      OP_STOP: begin
        n_stop++;
        work_items++;
        m_pan_tgt  = m_pan_pos;
        m_tilt_tgt = m_tilt_pos;
        m_pan_spd  = '0;
        m_tilt_spd = '0;
        m_done     = 1'b1;
      end
      default: n_other++;
    endcase
    s.pan_pos  = m_pan_pos;
    s.tilt_pos = m_tilt_pos;
    s.pan_vel  = m_pan_spd;
    s.tilt_vel = m_tilt_spd;
    s.done     = m_done;
    return s;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // status checker
  always @(posedge clk) begin : status_check
    axis_status_t want;
    if (!rst && stat_bus.valid && stat_bus.ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: status item with none expected, expected nothing actual pan %0d",
                 $time, stat_bus.pan_position);
      end else begin
        want = pending_status.pop_front();
        compare_field("pan_position", want.pan_pos, stat_bus.pan_position);
        compare_field("tilt_position", want.tilt_pos, stat_bus.tilt_position);
        compare_field("pan_velocity", want.pan_vel, stat_bus.pan_velocity);
        compare_field("tilt_velocity", want.tilt_vel, stat_bus.tilt_velocity);
        compare_field("move_done", want.done, stat_bus.move_done);
        results_checked++;
      end
    end
  end

  // status receiver, with an optional long hold-off
  initial begin
    stat_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stat_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stat_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (cmd_bus.valid && cmd_bus.ready) || (stat_bus.valid && stat_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d status items outstanding",
               $time, quiet_cycles, pending_status.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_cmd(input logic [1:0] op, input int dp, input int dt,
                          input int gp, input int gt);
    move_cmd_t c;
    int        gap;
    c.opcode     = op;
    c.delta_pan  = dp[DPAN_W-1:0];
    c.delta_tilt = dt[DTILT_W-1:0];
    c.gear_pan   = gp[GEAR_W-1:0];
    c.gear_tilt  = gt[GEAR_W-1:0];
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.opcode         <= c.opcode;
    cmd_bus.delta_pan      <= c.delta_pan;
    cmd_bus.delta_tilt     <= c.delta_tilt;
    cmd_bus.max_speed_pan  <= c.gear_pan;
    cmd_bus.max_speed_tilt <= c.gear_tilt;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    pending_status.push_back(advance_axes(c));
  endtask

  task automatic wait_drain();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_motion_config(input int gain, input int limit);
    logic [31:0] rd;
    wait_drain();
    apb_access(1'b1, {REG_STEP_GAIN, 2'b00}, gain, rd);
    m_gain = gain[GAIN_W-1:0];
    apb_access(1'b1, {REG_TILT_LIMIT, 2'b00}, limit, rd);
    m_tilt_lim = limit[LIMIT_W-1:0];
    apb_access(1'b0, {REG_STEP_GAIN, 2'b00}, '0, rd);
    compare_field("step_gain readback", m_gain, rd);
    apb_access(1'b0, {REG_TILT_LIMIT, 2'b00}, '0, rd);
    compare_field("tilt_limit readback", m_tilt_lim, rd);
    n_settings++;
  endtask

  task automatic set_idle(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // rotate, then tick until the move ends or the tick budget runs out
  task automatic run_move(input int dp, input int dt, input int gp, input int gt,
                          input int max_ticks);
    int n;
    send_cmd(OP_ROTATE, dp, dt, gp, gt);
    n = 0;
    while (!m_done && n < max_ticks) begin
      send_cmd(OP_TICK, $urandom, $urandom, $urandom, $urandom);
      n++;
    end
  endtask

  function automatic int rand_delta(int span);
    case ($urandom_range(9))
      0:       return span;
      1:       return -span;
      2:       return 0;
      3:       return int'($urandom_range(200)) - 100;
      default: return int'($urandom_range(2 * span)) - span;
    endcase
  endfunction

  function automatic int rand_gear();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 65) return $urandom_range(255, 128);
    return $urandom_range(255, 1);
  endfunction

  task automatic rand_traffic(input int n);
    int goal;
    int pick;
    goal = work_items + n;
    while (work_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_move(rand_delta(36000), rand_delta(18000), rand_gear(), rand_gear(),
                 $urandom_range(40, 2));
        if ($urandom_range(3) == 0)
          send_cmd(OP_STOP, $urandom, $urandom, $urandom, $urandom);
        else if ($urandom_range(3) == 0)
          send_cmd(OP_TICK, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 85) begin
        run_move(rand_delta(36000), rand_delta(18000), rand_gear(), rand_gear(),
                 $urandom_range(3, 0));
        send_cmd(OP_STOP, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_cmd($urandom_range(OP_UNUSED, OP_TICK), rand_delta(36000), rand_delta(18000),
                 rand_gear(), rand_gear());
      end
    end
  endtask

  task automatic test_idle_commands();
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_UNUSED, -1, -1, 255, 255);
    send_cmd(OP_STOP, 36000, 18000, 1, 1);
  endtask

  task automatic test_directed_moves();
    run_move(0, 0, 0, 0, 2);
    run_move(36000, 18000, 255, 255, 6);
    run_move(-36000, -18000, 0, 255, 3);
    send_cmd(OP_STOP, 0, 0, 0, 0);
    run_move(1, -1, 255, 1, 2);
    run_move(-1, 0, 1, 255, 2);
  endtask

  task automatic test_saturation();
    set_motion_config(1000, 32767);
    run_move(36000, 18000, 255, 255, 1);
    run_move(36000, 18000, 255, 255, 2);
    run_move(-36000, -18000, 255, 255, 2);
    set_motion_config(0, 0);
    run_move(500, 500, 10, 10, 2);
    send_cmd(OP_STOP, 0, 0, 0, 0);
    set_motion_config(GAIN_RESET, LIMIT_RESET);
  endtask

  task automatic test_config_sweep();
    set_idle(6, 50);
    set_motion_config(1, 0);
    rand_traffic(35);
    set_motion_config(1000, 18000);
    rand_traffic(35);
    set_motion_config(1023, 32767);
    rand_traffic(35);
    set_motion_config(0, 5800);
    rand_traffic(35);
    set_motion_config($urandom_range(1000, 1), $urandom_range(18000));
    rand_traffic(35);
    set_motion_config(GAIN_RESET, LIMIT_RESET);
  endtask

  task automatic test_backpressure();
    set_idle(0, 0);
    hold_off_req = 1'b1;
    rand_traffic(25);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    set_idle(6, 50);
    rand_traffic(400);
    set_idle(50, 6);
    rand_traffic(400);
    set_idle(0, 0);
    rand_traffic(400);
  endtask

  initial begin
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    cmd_bus.valid          = 1'b0;
    cmd_bus.opcode         = OP_TICK;
    cmd_bus.delta_pan      = '0;
    cmd_bus.delta_tilt     = '0;
    cmd_bus.max_speed_pan  = '0;
    cmd_bus.max_speed_tilt = '0;
    hold_off_req           = 1'b0;
    quiet_cycles           = 0;
    mismatches             = 0;
    results_checked        = 0;
    work_items             = 0;
    n_rotate               = 0;
    n_tick                 = 0;
    n_stop                 = 0;
    n_other                = 0;
    n_settings             = 0;
    m_pan_pos              = '0;
    m_pan_tgt              = '0;
    m_tilt_pos             = '0;
    m_tilt_tgt             = '0;
    m_pan_spd              = '0;
    m_tilt_spd             = '0;
    m_done                 = 1'b1;
    m_gain                 = GAIN_RESET;
    m_tilt_lim             = LIMIT_RESET;
    set_idle(0, 0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_directed_moves();
    test_saturation();
    test_config_sweep();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_status.size() != 0) begin
      mismatches++;
      $display("%0t: %0d status items never arrived", $time, pending_status.size());
    end
    $display("Covered %0d rotates, %0d ticks, %0d stops, %0d unused opcodes; %0d status checked",
             n_rotate, n_tick, n_stop, n_other, results_checked);
    $display("%0d register settings incl. gain/limit extremes, long output stall; %0d mismatches",
             n_settings, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
